FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the i2c bit sequencer
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/core/i2cms_pkg.sv
// types, codes and constants of the i2c master bit sequencer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package i2cms_pkg;

    // width of the phase hold counter and the default hold length
    localparam int HOLD_BITS = 16;
    localparam int CFG_W = 16;
    localparam logic [HOLD_BITS-1:0] DEFAULT_HOLD = HOLD_BITS'(10 * 20);

    // phase numbering; phase_index holds phase plus one, zero means idle
    localparam int PHASE_W = 5;
    localparam logic [PHASE_W-1:0] SEND_BIT_PHASES = PHASE_W'(24);
    localparam logic [PHASE_W-1:0] SEND_LAST_PHASE = PHASE_W'(25);
    localparam logic [PHASE_W-1:0] RECV_LAST_PHASE = PHASE_W'(15);
    localparam logic [PHASE_W-1:0] MAX_PHASE_INDEX = PHASE_W'(26);

    // msb of the shift register and the sda sample bit
    localparam logic [7:0] BYTE_MSB = 8'h80;
    localparam logic [7:0] BIT_LSB = 8'h01;

    typedef enum logic [2:0] {
        KIND_START = 3'd0,
        KIND_SHT   = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_SEND  = 3'd3,
        KIND_RECV  = 3'd4,
        KIND_ACK   = 3'd5,
        KIND_NACK  = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_READY = 3'd0,
        ST_BUSY  = 3'd1,
        ST_ERROR = 3'd2,
        ST_ACK   = 3'd3,
        ST_NACK  = 3'd4
    } status_t;

    // one input item: a tick with an optional command
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic       sda_in;
    } cmd_t;

    // one result item: line levels and status after the tick
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] rx_byte;
    } res_t;

    // sequencer state carried from tick to tick
    typedef struct packed {
        logic [PHASE_W-1:0]   phase_index;
        logic [HOLD_BITS-1:0] hold_counter;
        logic [7:0]           shift_register;
        logic [2:0]           active_command;
        status_t              last_status;
        logic [7:0]           received_byte;
        logic                 scl_level;
        logic                 sda_level;
    } seq_state_t;

endpackage

FILE: rtl/core/i2cms_step.sv
// next-state and result logic for one tick of the i2c bit sequencer
// depends on i2cms_pkg
`timescale 1ns / 1ps

module i2cms_step (
    input  i2cms_pkg::seq_state_t           cur,
    input  i2cms_pkg::cmd_t                 item,
    input  logic [i2cms_pkg::CFG_W-1:0]     phase_hold_ticks,
    output i2cms_pkg::seq_state_t           nxt,
    output i2cms_pkg::res_t                 res
);
    import i2cms_pkg::*;

    // remainder by three for send phases below 24
    function automatic logic [1:0] mod3(input logic [PHASE_W-1:0] v);
        logic [PHASE_W-1:0] r;
        r = v;
        if (r >= PHASE_W'(12))
        begin
            r = r - PHASE_W'(12);
        end
        if (r >= PHASE_W'(6))
        begin
            r = r - PHASE_W'(6);
        end
        if (r >= PHASE_W'(3))
        begin
            r = r - PHASE_W'(3);
        end
        return r[1:0];
    endfunction

    // line levels {scl, sda} at the start of phase p
    function automatic logic [1:0] enter_lines(
        input logic [2:0]         cmd,
        input logic [PHASE_W-1:0] p,
        input logic [7:0]         shreg,
        input logic [1:0]         lines
    );
        logic scl;
        logic sda;
        scl = lines[1];
        sda = lines[0];
        case (cmd)
            KIND_START:
            begin
                if (p == PHASE_W'(0)) sda = 1'b1;
                else if (p == PHASE_W'(1)) scl = 1'b1;
                else if (p == PHASE_W'(2)) sda = 1'b0;
                else scl = 1'b0;
            end
            KIND_SHT:
            begin
                if (p == PHASE_W'(0))
                begin
                    sda = 1'b1;
                    scl = 1'b0;
                end
                else if (p == PHASE_W'(1))
                begin
                    sda = 1'b1;
                    scl = 1'b1;
                end
                else if (p == PHASE_W'(2)) sda = 1'b0;
                else if (p == PHASE_W'(3)) scl = 1'b0;
                else if (p == PHASE_W'(4)) scl = 1'b1;
                else if (p == PHASE_W'(5)) sda = 1'b1;
                else scl = 1'b0;
            end
            KIND_STOP:
            begin
                if (p == PHASE_W'(0)) sda = 1'b0;
                else if (p == PHASE_W'(1)) scl = 1'b1;
                else sda = 1'b1;
            end
            KIND_SEND:
            begin
                if (p < SEND_BIT_PHASES)
                begin
                    case (mod3(p))
                        2'd0:
                        begin
                            scl = 1'b0;
                            sda = |(shreg & BYTE_MSB);
                        end
                        2'd1:    scl = 1'b1;
                        default: scl = 1'b0;
                    endcase
                end
                else if (p == SEND_BIT_PHASES) sda = 1'b1;
                else scl = 1'b1;
            end
            KIND_RECV:
            begin
                if (!p[0])
                begin
                    scl = 1'b1;
                    sda = 1'b1;
                end
                else scl = 1'b0;
            end
            KIND_ACK:
            begin
                if (p == PHASE_W'(0)) sda = 1'b0;
                else if (p == PHASE_W'(1)) scl = 1'b1;
                else scl = 1'b0;
            end
            default:
            begin
                if (p == PHASE_W'(0)) sda = 1'b1;
                else if (p == PHASE_W'(1)) scl = 1'b1;
                else scl = 1'b0;
            end
        endcase
        return {scl, sda};
    endfunction

    logic [HOLD_BITS-1:0] hold_raw;
    logic [HOLD_BITS-1:0] hold_len;
    logic [HOLD_BITS:0]   count_inc;
    logic [PHASE_W-1:0]   p;
    logic                 fin;
    logic                 done;

    // effective hold length, zero picks the default
    assign hold_raw = HOLD_BITS'(phase_hold_ticks);
    assign hold_len = (hold_raw == '0) ? DEFAULT_HOLD : hold_raw;

    // command start, hold count and end of phase for this tick
    always_comb
    begin
        nxt       = cur;
        fin       = 1'b0;
        done      = 1'b0;
        count_inc = '0;
        p         = '0;

        // accept a command while idle
        if (cur.phase_index == '0 && item.cmd_valid && item.kind <= KIND_NACK)
        begin
            nxt.active_command = item.kind;
            nxt.shift_register = item.tx_byte;
            nxt.hold_counter   = '0;
            nxt.phase_index    = PHASE_W'(1);
            {nxt.scl_level, nxt.sda_level} =
                enter_lines(item.kind, '0, item.tx_byte, {cur.scl_level, cur.sda_level});
        end

        // count the tick and finish the phase when the hold expires
        if (nxt.phase_index != '0)
        begin
            count_inc = {1'b0, nxt.hold_counter} + (HOLD_BITS+1)'(1);
            if (count_inc >= {1'b0, hold_len})
            begin
                p = nxt.phase_index - PHASE_W'(1);
                nxt.hold_counter = '0;
                case (nxt.active_command)
                    KIND_START:
                    begin
                        if (p == PHASE_W'(1) && !item.sda_in)
                        begin
                            nxt.last_status = ST_BUSY;
                            fin = 1'b1;
                        end
                        else if (p == PHASE_W'(3))
                        begin
                            nxt.last_status = item.sda_in ? ST_ERROR : ST_READY;
                            fin = 1'b1;
                        end
                    end
                    KIND_SHT:
                    begin
                        if (p == PHASE_W'(1) && !item.sda_in)
                        begin
                            nxt.last_status = ST_BUSY;
                            fin = 1'b1;
                        end
                        else if (p == PHASE_W'(6))
                        begin
                            nxt.last_status = ST_READY;
                            fin = 1'b1;
                        end
                    end
                    KIND_STOP:
                    begin
                        fin = (p == PHASE_W'(2));
                    end
                    KIND_SEND:
                    begin
                        if (p < SEND_BIT_PHASES && mod3(p) == 2'd2)
                        begin
                            nxt.shift_register = {nxt.shift_register[6:0], 1'b0};
                        end
                        if (p == SEND_LAST_PHASE)
                        begin
                            nxt.last_status = item.sda_in ? ST_NACK : ST_ACK;
                            nxt.scl_level   = 1'b0;
                            nxt.sda_level   = 1'b1;
                            fin = 1'b1;
                        end
                    end
                    KIND_RECV:
                    begin
                        if (!p[0])
                        begin
                            nxt.shift_register = {nxt.shift_register[6:0], 1'b0}
                                               | ({8{item.sda_in}} & BIT_LSB);
                        end
                        if (p == RECV_LAST_PHASE)
                        begin
                            nxt.received_byte = nxt.shift_register;
                            fin = 1'b1;
                        end
                    end
                    KIND_ACK:
                    begin
                        if (p == PHASE_W'(2))
                        begin
                            nxt.sda_level = 1'b1;
                            fin = 1'b1;
                        end
                    end
                    default:
                    begin
                        fin = (p == PHASE_W'(2));
                    end
                endcase

                if (fin)
                begin
                    nxt.phase_index = '0;
                    done = 1'b1;
                end
                else
                begin
                    nxt.phase_index = nxt.phase_index + PHASE_W'(1);
                    {nxt.scl_level, nxt.sda_level} =
                        enter_lines(nxt.active_command, p + PHASE_W'(1),
                                    nxt.shift_register, {nxt.scl_level, nxt.sda_level});
                end
            end
            else
            begin
                nxt.hold_counter = count_inc[HOLD_BITS-1:0];
            end
        end
    end

    // result item for this tick
    always_comb
    begin
        res.scl_out  = nxt.scl_level;
        res.sda_out  = nxt.sda_level;
        res.busy_res = (nxt.phase_index != '0);
        res.done_res = done;
        res.status   = nxt.last_status;
        res.rx_byte  = nxt.received_byte;
    end

endmodule

FILE: rtl/core/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: one input item per tick, one result item per tick.
// An item is registered on entry, stepped through the sequencer logic and its
// result registered on exit; one item is taken every cycle when the output is
// not stalled, and its result passes the input register and then the result
// register. Rate is set by the single step unit (i2cms_step), which updates
// the sequencer state once per item. A command runs through its line phases,
// each held for phase_hold_ticks items (zero means 200). The user writes the
// hold register with cfg_we only while no item is in flight; the block itself does not enforce it.
// depends on i2cms_pkg, i2cms_step and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_master_bit_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  i2cms_pkg::cmd_t                  in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output i2cms_pkg::res_t                  out_data,
    input  logic                             cfg_we,
    input  logic [i2cms_pkg::CFG_W-1:0]      cfg_wdata
);
    import i2cms_pkg::*;

    logic                in_valid_reg;
    cmd_t                in_data_reg;
    logic                out_valid_reg;
    res_t                res_reg;
    seq_state_t          state_reg;
    seq_state_t          state_next;
    res_t                res_next;
    logic [CFG_W-1:0]    hold_cfg_reg;
    logic                proceed;

    // step the held item when the result register is free or draining
    assign proceed  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !proceed;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            hold_cfg_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_data_reg <= in_data;
        end
    end

    // tick logic
    i2cms_step u_step (
        .cur              (state_reg),
        .item             (in_data_reg),
        .phase_hold_ticks (hold_cfg_reg),
        .nxt              (state_next),
        .res              (res_next)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase_index    <= '0;
            state_reg.hold_counter   <= '0;
            state_reg.shift_register <= '0;
            state_reg.active_command <= KIND_START;
            state_reg.last_status    <= ST_READY;
            state_reg.received_byte  <= '0;
            state_reg.scl_level      <= 1'b0;
            state_reg.sda_level      <= 1'b1;
        end
        else if (proceed)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proceed)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    // checks
    `ASSERT_CLK(a_step_fills_result, clk, rst_n, proceed |=> out_valid_reg, "stepped item lost")
    `ASSERT_NEVER(a_done_not_busy, clk, rst_n,
        out_valid_reg && res_reg.done_res && res_reg.busy_res, "done while busy")
    `ASSERT_NEVER(a_phase_range, clk, rst_n,
        state_reg.phase_index > MAX_PHASE_INDEX, "phase out of range")
    `ASSERT_CLK(a_idle_state_hold, clk, rst_n, !proceed |=> $stable(state_reg), "state moved")

endmodule
